// ===== src/tpkt_cotp_header_scanner_macros.svh =====
// Assertion macros shared by the TPKT/COTP header scanner modules.
// Each macro expands to a concurrent assertion, or to nothing when SYNTH is defined.
`ifndef TPKT_COTP_HEADER_SCANNER_MACROS_SVH
`define TPKT_COTP_HEADER_SCANNER_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define TCS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("tcs: assertion failed");
// The consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tcs: implication failed");
// The consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tcs: next-cycle implication failed");
`else
`define TCS_ASSERT(lbl, clk, rstn, prop)
`define TCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/tcs_pkg.sv =====
// Package of the TPKT/COTP header scanner: configuration type, register indexes
// and status codes. No dependencies.
`default_nettype none

package tcs_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_VERSION_BYTE    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_TPKT_MIN_LENGTH = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_COTP_MIN_LENGTH = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_CR_TYPE_CODE    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_DT_TYPE_CODE    = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_PROTOCOL_ID     = 3'd5;

	localparam logic [1:0] STATUS_CONT   = 2'd0;
	localparam logic [1:0] STATUS_SEARCH = 2'd1;
	localparam logic [1:0] STATUS_FLUSH  = 2'd2;
	localparam logic [1:0] STATUS_ABORT  = 2'd3;

	typedef struct packed {
		logic [7:0]  version_byte;
		logic [15:0] tpkt_min_length;
		logic [7:0]  cotp_min_length;
		logic [3:0]  cr_type_code;
		logic [3:0]  dt_type_code;
		logic [7:0]  protocol_id;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/tcs_in_if.sv =====
// Byte channel of the TPKT/COTP header scanner: one stream byte per item.
// No dependencies.
`default_nettype none

interface tcs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_segment;

	modport source (output valid, output data_byte, output end_of_segment, input ready);
	modport sink (input valid, input data_byte, input end_of_segment, output ready);
endinterface

`default_nettype wire

// ===== src/tcs_out_if.sv =====
// Result channel of the TPKT/COTP header scanner: one verdict per item.
// No dependencies.
`default_nettype none

interface tcs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] flush_length;

	modport source (output valid, output status, output flush_length, input ready);
	modport sink (input valid, input status, input flush_length, output ready);
endinterface

`default_nettype wire

// ===== src/tcs_cfg.sv =====
// Configuration register file of the TPKT/COTP header scanner.
// Depends on tcs_pkg.
`default_nettype none

module tcs_cfg
	import tcs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_byte    <= 8'd3;
			cfg_q.tpkt_min_length <= 16'd7;
			cfg_q.cotp_min_length <= 8'd2;
			cfg_q.cr_type_code    <= 4'd14;
			cfg_q.dt_type_code    <= 4'd15;
			cfg_q.protocol_id     <= 8'd114;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERSION_BYTE:    cfg_q.version_byte    <= cfg_wdata[7:0];
				CFG_TPKT_MIN_LENGTH: cfg_q.tpkt_min_length <= cfg_wdata;
				CFG_COTP_MIN_LENGTH: cfg_q.cotp_min_length <= cfg_wdata[7:0];
				CFG_CR_TYPE_CODE:    cfg_q.cr_type_code    <= cfg_wdata[3:0];
				CFG_DT_TYPE_CODE:    cfg_q.dt_type_code    <= cfg_wdata[3:0];
				CFG_PROTOCOL_ID:     cfg_q.protocol_id     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/tcs_parse.sv =====
// Header parser state machine of the TPKT/COTP header scanner: parse state,
// gathered TPKT length and the per-byte verdict. Depends on tcs_pkg.
`default_nettype none
`include "tpkt_cotp_header_scanner_macros.svh"

module tcs_parse
	import tcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_segment,
	output logic [1:0]       status,
	output logic [15:0]      flush_length
);

	localparam logic [3:0] ST_VER      = 4'd0;
	localparam logic [3:0] ST_RSV      = 4'd1;
	localparam logic [3:0] ST_LEN_HI   = 4'd2;
	localparam logic [3:0] ST_LEN_LO   = 4'd3;
	localparam logic [3:0] ST_COTP_LEN = 4'd4;
	localparam logic [3:0] ST_PDU      = 4'd5;
	localparam logic [3:0] ST_REF0     = 4'd6;
	localparam logic [3:0] ST_REF1     = 4'd7;
	localparam logic [3:0] ST_REF2     = 4'd8;
	localparam logic [3:0] ST_REF3     = 4'd9;
	localparam logic [3:0] ST_CLASS    = 4'd10;
	localparam logic [3:0] ST_DT_EOT   = 4'd11;
	localparam logic [3:0] ST_PROTO    = 4'd12;

	logic [3:0]  state_q, state_d;
	logic [15:0] frame_q, frame_d;
	logic [1:0]  verdict;
	logic [15:0] full_len;
	logic [3:0]  pdu_type;
	logic        pdu_bad;

	assign full_len = frame_q | {8'h00, data_byte};
	assign pdu_type = data_byte[7:4];
	// Reserved PDU types and a nonzero flag nibble are refused outright.
	assign pdu_bad  = (pdu_type == 4'h0) || (pdu_type == 4'h3) || (pdu_type == 4'h9)
		|| (pdu_type == 4'hA) || (data_byte[3:0] != 4'h0);

	always_comb begin
		verdict = STATUS_CONT;
		state_d = state_q;
		frame_d = frame_q;
		unique case (state_q)
			ST_VER: begin
				if (data_byte != cfg.version_byte) verdict = STATUS_ABORT;
				else state_d = ST_RSV;
			end
			ST_RSV: begin
				if (data_byte != 8'h00) verdict = STATUS_ABORT;
				else state_d = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				frame_d = {data_byte, 8'h00};
				state_d = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				frame_d = full_len;
				if (full_len < cfg.tpkt_min_length) verdict = STATUS_ABORT;
				else state_d = ST_COTP_LEN;
			end
			ST_COTP_LEN: begin
				if (data_byte < cfg.cotp_min_length) verdict = STATUS_ABORT;
				else state_d = ST_PDU;
			end
			ST_PDU: begin
				// A type equal to both codes is taken as a connection request.
				if (pdu_bad) verdict = STATUS_ABORT;
				else if (pdu_type == cfg.cr_type_code) state_d = ST_REF0;
				else if (pdu_type == cfg.dt_type_code) state_d = ST_DT_EOT;
				else verdict = STATUS_FLUSH;
			end
			ST_REF0, ST_REF1, ST_REF2, ST_REF3: begin
				state_d = state_q + 4'd1;
			end
			ST_CLASS: begin
				verdict = (data_byte == 8'h00 || data_byte == 8'h10) ? STATUS_FLUSH
					: STATUS_ABORT;
			end
			ST_DT_EOT: begin
				if (data_byte[7]) state_d = ST_PROTO;
				else verdict = STATUS_FLUSH;
			end
			ST_PROTO: begin
				verdict = (data_byte == cfg.protocol_id) ? STATUS_FLUSH : STATUS_ABORT;
			end
			default: verdict = STATUS_ABORT;
		endcase

		if (verdict != STATUS_CONT) begin
			state_d = ST_VER;
			frame_d = 16'h0000;
		end
	end

	always_comb begin
		if (verdict == STATUS_CONT) begin
			status       = end_of_segment ? STATUS_SEARCH : STATUS_CONT;
			flush_length = 16'h0000;
		end else begin
			status       = verdict;
			flush_length = (verdict == STATUS_FLUSH) ? frame_q : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_VER;
			frame_q <= 16'h0000;
		end else if (step) begin
			state_q <= state_d;
			frame_q <= frame_d;
		end
	end

	`TCS_ASSERT(a_state_known, clk, arst_n, state_q <= ST_PROTO)
	`TCS_ASSERT_NEXT(a_restart, clk, arst_n, step && (status == STATUS_FLUSH || status == STATUS_ABORT), state_q == ST_VER && frame_q == 16'h0000)
	`TCS_ASSERT_NEXT(a_len_low_clear, clk, arst_n, step && state_q == ST_LEN_HI, frame_q[7:0] == 8'h00)

endmodule

`default_nettype wire

// ===== src/tpkt_cotp_header_scanner.sv =====
// Top level of the TPKT/COTP header scanner: input register, parser, result register.
// Depends on tcs_pkg, tcs_in_if, tcs_out_if, tcs_cfg and tcs_parse.
//
//   Channel     Role    Payload                         Handshake
//   byte_ch     sink    data_byte[7:0], end_of_segment  valid/ready
//   verdict_ch  source  status[1:0], flush_length[15:0] valid/ready
//   cfg         write   cfg_index[2:0], cfg_wdata[15:0] cfg_we, no wait
//
// Every stream byte yields exactly one verdict: the byte waits in the input register,
// the parser decides it combinationally when it advances, and the verdict sits in the
// result register until taken. A new byte can be taken every cycle unless the result
// register is held by a stall.
// Reset (arst_n low) clears both pipeline valid bits, the parser state and the
// registers to their defaults. When the result register is held by a stall, the
// input register still fills, so one byte is absorbed before byte_ch.ready drops.
`default_nettype none
`include "tpkt_cotp_header_scanner_macros.svh"

module tpkt_cotp_header_scanner
	import tcs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_wdata,
	tcs_in_if.sink                   byte_ch,
	tcs_out_if.source                verdict_ch
);

	cfg_t        cfg;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        advance;
	logic [1:0]  step_status;
	logic [15:0] step_len;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [15:0] flen_q;

	tcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The byte in the input register is parsed when the result register can
	// take its verdict: either it is empty or its verdict leaves this cycle.
	assign advance       = valid_s1 && (!out_valid_q || verdict_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			eos_s1  <= byte_ch.end_of_segment;
		end
	end

	tcs_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.step           (advance),
		.data_byte      (byte_s1),
		.end_of_segment (eos_s1),
		.status         (step_status),
		.flush_length   (step_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= step_status;
			flen_q   <= step_len;
		end
	end

	assign verdict_ch.valid        = out_valid_q;
	assign verdict_ch.status       = status_q;
	assign verdict_ch.flush_length = flen_q;

	`TCS_ASSERT_IMPL(a_len_only_on_flush, clk, arst_n, out_valid_q && status_q != STATUS_FLUSH, flen_q == 16'h0000)
	`TCS_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, byte_ch.valid && byte_ch.ready, valid_s1)
	`TCS_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(eos_s1))

endmodule

`default_nettype wire

// ===== tb/sv/tpkt_cotp_header_scanner_tb.sv =====
// Self-checking testbench of the TPKT/COTP header scanner: a stimulus table, then framed
// random byte streams under several register settings, checked against a local scan model.
// Depends on tcs_pkg, tcs_in_if, tcs_out_if and tpkt_cotp_header_scanner.

module tpkt_cotp_header_scanner_tb;
	import tcs_pkg::*;

	// Timing and run-length knobs. The cycle limit is many times the slowest legal run:
	// about 1500 items with random idle gaps on each side plus the pipeline latency,
	// two long receiver hold-offs and the register phases.
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned PHASES          = 7;
	localparam int unsigned ITEMS_PER_PHASE = 205;
	localparam int unsigned HOLD_CYCLES     = 150;
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned PROBE_COUNT     = 27;

	// Register indexes past the end of the list; writes to them must be ignored.
	localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

	// PDU type nibbles that always abort, and the two accepted class bytes.
	localparam logic [3:0] PDU_RSVD_0 = 4'h0;
	localparam logic [3:0] PDU_RSVD_3 = 4'h3;
	localparam logic [3:0] PDU_RSVD_9 = 4'h9;
	localparam logic [3:0] PDU_RSVD_A = 4'hA;
	localparam logic [7:0] CLASS_0    = 8'h00;
	localparam logic [7:0] CLASS_1    = 8'h10;
	localparam int unsigned EOT_BIT   = 7;

	localparam cfg_t CFG_RESET = '{
		version_byte: 8'd3, tpkt_min_length: 16'd7, cotp_min_length: 8'd2,
		cr_type_code: 4'd14, dt_type_code: 4'd15, protocol_id: 8'd114
	};

	typedef enum logic [3:0] {
		SCAN_VERSION, SCAN_RESERVED, SCAN_LEN_HI, SCAN_LEN_LO, SCAN_COTP_LEN,
		SCAN_PDU_TYPE, SCAN_REF_0, SCAN_REF_1, SCAN_REF_2, SCAN_REF_3,
		SCAN_CLASS, SCAN_DT_EOT, SCAN_PROTO_ID
	} scan_state_e;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] flen;
	} verdict_t;

	// Each offered byte carries a note: typed notes hold a verdict written in the table,
	// the others leave the verdict to the scan model.
	typedef struct packed {
		logic     typed;
		verdict_t verdict;
	} byte_note_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        eos;
		logic        typed;
		logic [1:0]  status;
		logic [15:0] flen;
	} probe_row_t;

	// Directed stream, all under the reset register values. It walks a wrong version with
	// and without the segment mark, a data transfer with the end-of-transfer bit and a
	// matching protocol id at the largest length, the smallest length with the largest COTP
	// length and a type that flushes at once, and a connection request ending in class 1.
	localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
		'{8'h05, 1'b0, 1'b1, STATUS_ABORT,  16'h0000},
		'{8'h03, 1'b0, 1'b1, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b1, 1'b1, STATUS_SEARCH, 16'h0000},
		'{8'hFF, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hFF, 1'b1, 1'b1, STATUS_SEARCH, 16'h0000},
		'{8'h02, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hF0, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h80, 1'b1, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h72, 1'b1, 1'b1, STATUS_FLUSH,  16'hFFFF},
		'{8'h03, 1'b1, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h07, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hFF, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hD0, 1'b1, 1'b1, STATUS_FLUSH,  16'h0007},
		'{8'h03, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h07, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h02, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hE0, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hFF, 1'b1, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h00, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'hFF, 1'b0, 1'b0, STATUS_CONT,   16'h0000},
		'{8'h10, 1'b0, 1'b1, STATUS_FLUSH,  16'h0007},
		'{8'hFF, 1'b1, 1'b1, STATUS_ABORT,  16'h0000}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_wdata;

	tcs_in_if  byte_ch();
	tcs_out_if verdict_ch();

	tpkt_cotp_header_scanner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.byte_ch   (byte_ch),
		.verdict_ch(verdict_ch)
	);

	always #6 clk = ~clk;

	// Scan model state: its own copy of the registers, the parse position and the length.
	cfg_t        scan_cfg = CFG_RESET;
	scan_state_e scan_state = SCAN_VERSION;
	logic [15:0] frame_len = '0;

	// Notes of offered bytes not yet accepted, and verdicts owed by the block, oldest first.
	byte_note_t  byte_notes[$];
	verdict_t    verdicts_due[$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned bytes_offered = 0;
	cfg_t        phase_cfg;
	bit          send_steady = 1'b0;
	bit          recv_steady = 1'b0;
	bit          hold_req = 1'b0;

	// Advances the scan model by one stream byte and returns the verdict it owes.
	// Flush and abort both send the parser back to the version byte.
	function automatic verdict_t scan_byte(input logic [7:0] b, input logic eos);
		logic [1:0] outcome;
		verdict_t   v;
		outcome = STATUS_CONT;
		v = '0;
		case (scan_state)
			SCAN_VERSION: begin
				if (b != scan_cfg.version_byte) outcome = STATUS_ABORT;
				else scan_state = SCAN_RESERVED;
			end
			SCAN_RESERVED: begin
				if (b != 8'h00) outcome = STATUS_ABORT;
				else scan_state = SCAN_LEN_HI;
			end
			SCAN_LEN_HI: begin
				frame_len = {b, 8'h00};
				scan_state = SCAN_LEN_LO;
			end
			SCAN_LEN_LO: begin
				frame_len[7:0] = b;
				if (frame_len < scan_cfg.tpkt_min_length) outcome = STATUS_ABORT;
				else scan_state = SCAN_COTP_LEN;
			end
			SCAN_COTP_LEN: begin
				if (b < scan_cfg.cotp_min_length) outcome = STATUS_ABORT;
				else scan_state = SCAN_PDU_TYPE;
			end
			SCAN_PDU_TYPE: begin
				// Reserved types and any flag bit abort before the configured codes are
				// looked at; a request code wins over an equal transfer code.
				if (b[7:4] == PDU_RSVD_0 || b[7:4] == PDU_RSVD_3 ||
						b[7:4] == PDU_RSVD_9 || b[7:4] == PDU_RSVD_A || b[3:0] != 4'h0) begin
					outcome = STATUS_ABORT;
				end else if (b[7:4] == scan_cfg.cr_type_code) begin
					scan_state = SCAN_REF_0;
				end else if (b[7:4] == scan_cfg.dt_type_code) begin
					scan_state = SCAN_DT_EOT;
				end else begin
					outcome = STATUS_FLUSH;
				end
			end
			SCAN_REF_0, SCAN_REF_1, SCAN_REF_2, SCAN_REF_3: begin
				scan_state = scan_state_e'(scan_state + 4'd1);
			end
			SCAN_CLASS: begin
				outcome = (b == CLASS_0 || b == CLASS_1) ? STATUS_FLUSH : STATUS_ABORT;
			end
			SCAN_DT_EOT: begin
				if (b[EOT_BIT]) scan_state = SCAN_PROTO_ID;
				else outcome = STATUS_FLUSH;
			end
			SCAN_PROTO_ID: begin
				outcome = (b == scan_cfg.protocol_id) ? STATUS_FLUSH : STATUS_ABORT;
			end
			default: begin
				outcome = STATUS_ABORT;
			end
		endcase
		if (outcome == STATUS_CONT) begin
			v.status = eos ? STATUS_SEARCH : STATUS_CONT;
		end else begin
			v.status = outcome;
			if (outcome == STATUS_FLUSH) v.flen = frame_len;
			scan_state = SCAN_VERSION;
			frame_len = '0;
		end
		return v;
	endfunction

	// One process watches both channels and the register port at each rising edge. It
	// reads values from before the edge's updates, so the order of processes does not
	// matter. A verdict is checked before the byte of the same edge is predicted; the
	// block registers each byte, then its verdict, so no edge carries its own byte's verdict.
	verdict_t   seen_want;
	verdict_t   seen_model;
	byte_note_t seen_note;

	always @(posedge clk) begin
		if (arst_n) begin
			if (verdict_ch.valid && verdict_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("unexpected item: status %0d, flush_length %0d",
						verdict_ch.status, verdict_ch.flush_length);
					fail_count++;
				end else begin
					seen_want = verdicts_due.pop_front();
					if (verdict_ch.status !== seen_want.status) begin
						$error("status: expected %0d, actual %0d",
							seen_want.status, verdict_ch.status);
						fail_count++;
					end
					if (verdict_ch.flush_length !== seen_want.flen) begin
						$error("flush_length: expected %0d, actual %0d",
							seen_want.flen, verdict_ch.flush_length);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_VERSION_BYTE:    scan_cfg.version_byte = cfg_wdata[7:0];
					CFG_TPKT_MIN_LENGTH: scan_cfg.tpkt_min_length = cfg_wdata;
					CFG_COTP_MIN_LENGTH: scan_cfg.cotp_min_length = cfg_wdata[7:0];
					CFG_CR_TYPE_CODE:    scan_cfg.cr_type_code = cfg_wdata[3:0];
					CFG_DT_TYPE_CODE:    scan_cfg.dt_type_code = cfg_wdata[3:0];
					CFG_PROTOCOL_ID:     scan_cfg.protocol_id = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (byte_ch.valid && byte_ch.ready) begin
				// The model runs on every byte to keep its state; a typed note overrides
				// its verdict for the table rows that carry one.
				seen_note = byte_notes.pop_front();
				seen_model = scan_byte(byte_ch.data_byte, byte_ch.end_of_segment);
				verdicts_due.push_back(seen_note.typed ? seen_note.verdict : seen_model);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tpkt_cotp_header_scanner test failed");
			$finish;
		end
	end

	// Receiver: before each verdict it idles for a drawn number of cycles, or for a long
	// hold-off when one is requested, while the sender keeps offering bytes so that the
	// result register, then the input register, fills and byte_ch.ready drops.
	initial begin
		int unsigned idle;
		verdict_ch.ready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				idle = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				idle = recv_steady ? 0 : $urandom_range(0, 16);
			end
			if (idle != 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
		end
	end

	// Offers one byte after a drawn gap and returns at the edge that accepts it. Valid
	// stays high on return so that back-to-back bytes need no second assignment.
	task automatic send_byte(input logic [7:0] b, input logic eos, input byte_note_t note);
		int unsigned gap;
		gap = send_steady ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_notes.push_back(note);
		byte_ch.data_byte <= b;
		byte_ch.end_of_segment <= eos;
		byte_ch.valid <= 1'b1;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_offered++;
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// Registers change only with the block idle: every byte taken and every verdict back,
	// then a few spare cycles. The spare indexes get random data that must change nothing.
	task automatic program_regs(input cfg_t c);
		byte_ch.valid <= 1'b0;
		while (byte_notes.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_VERSION_BYTE, {8'h00, c.version_byte});
		write_reg(CFG_TPKT_MIN_LENGTH, c.tpkt_min_length);
		write_reg(CFG_COTP_MIN_LENGTH, {8'h00, c.cotp_min_length});
		write_reg(CFG_CR_TYPE_CODE, {12'h000, c.cr_type_code});
		write_reg(CFG_DT_TYPE_CODE, {12'h000, c.dt_type_code});
		write_reg(CFG_PROTOCOL_ID, {8'h00, c.protocol_id});
		write_reg(CFG_SPARE_LO, 16'($urandom));
		write_reg(CFG_SPARE_HI, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Register settings per phase: all at their minimum, all at their maximum (request and
	// transfer codes then equal), the reset values, both codes on reserved types, equal
	// codes with random values, and fully random settings.
	function automatic cfg_t phase_setting(input int unsigned p);
		cfg_t c;
		c.version_byte = 8'($urandom);
		c.tpkt_min_length = 16'($urandom);
		c.cotp_min_length = 8'($urandom);
		c.cr_type_code = 4'($urandom);
		c.dt_type_code = 4'($urandom);
		c.protocol_id = 8'($urandom);
		case (p)
			0: c = '0;
			1: c = '1;
			2: c = CFG_RESET;
			3: begin
				c.cr_type_code = PDU_RSVD_3;
				c.dt_type_code = PDU_RSVD_9;
			end
			4: c.dt_type_code = c.cr_type_code;
			default: ;
		endcase
		return c;
	endfunction

	// Mostly the value a well-formed header needs, now and then any byte at all.
	function automatic logic [7:0] mostly(input logic [7:0] good);
		return ($urandom_range(0, 7) == 0) ? 8'($urandom) : good;
	endfunction

	// Builds and sends one burst of bytes. Most bursts are headers that follow the current
	// settings with random content, so that the request and transfer paths are reached;
	// the rest are pure noise, and some headers are cut short so the next one starts
	// mid-frame.
	task automatic send_frame();
		logic [7:0]  burst[$];
		logic [15:0] len;
		logic [7:0]  pdu;
		int unsigned path;
		int unsigned keep;
		byte_note_t  plain;
		plain = '0;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) burst.push_back(8'($urandom));
		end else begin
			burst.push_back(mostly(phase_cfg.version_byte));
			burst.push_back(mostly(8'h00));
			if ($urandom_range(0, 7) == 0) len = 16'($urandom);
			else len = 16'($urandom_range(32'hFFFF, phase_cfg.tpkt_min_length));
			burst.push_back(len[15:8]);
			burst.push_back(len[7:0]);
			if ($urandom_range(0, 7) == 0) burst.push_back(8'($urandom));
			else burst.push_back(8'($urandom_range(32'hFF, phase_cfg.cotp_min_length)));
			path = $urandom_range(0, 5);
			case (path)
				0, 1: pdu = {phase_cfg.cr_type_code, 4'h0};
				2, 3: pdu = {phase_cfg.dt_type_code, 4'h0};
				4: pdu = {4'($urandom), 4'h0};
				default: pdu = 8'($urandom);
			endcase
			burst.push_back(pdu);
			if (path <= 1) begin
				repeat (4) burst.push_back(8'($urandom));
				case ($urandom_range(0, 2))
					0: burst.push_back(CLASS_0);
					1: burst.push_back(CLASS_1);
					default: burst.push_back(8'($urandom));
				endcase
			end else if (path <= 3) begin
				burst.push_back(8'($urandom));
				if (burst[burst.size()-1][EOT_BIT]) burst.push_back(mostly(phase_cfg.protocol_id));
			end
			if ($urandom_range(0, 11) == 0) begin
				keep = $urandom_range(1, burst.size() - 1);
				while (burst.size() > keep) burst.delete(burst.size() - 1);
			end
		end
		foreach (burst[i]) send_byte(burst[i], ($urandom_range(0, 3) == 0), plain);
	endtask

	initial begin
		int unsigned phase_start;
		byte_note_t  note;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.end_of_segment <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table under the reset register values.
		for (int unsigned row = 0; row < PROBE_COUNT; row++) begin
			note.typed = PROBE_ROWS[row].typed;
			note.verdict.status = PROBE_ROWS[row].status;
			note.verdict.flen = PROBE_ROWS[row].flen;
			send_byte(PROBE_ROWS[row].data, PROBE_ROWS[row].eos, note);
		end

		// Random phases. In two of every three phases one side runs without idling; two phases
		// start with a long receiver hold-off to push the block into back-pressure.
		for (int unsigned p = 0; p < PHASES; p++) begin
			phase_cfg = phase_setting(p);
			send_steady = (p % 3 == 1);
			recv_steady = (p % 3 == 2);
			program_regs(phase_cfg);
			if (p == 2 || p == 5) hold_req = 1'b1;
			phase_start = bytes_offered;
			while (bytes_offered - phase_start < ITEMS_PER_PHASE) send_frame();
		end

		byte_ch.valid <= 1'b0;
		while (byte_notes.size() != 0 || verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tpkt_cotp_header_scanner test passed");
		end else begin
			$display("tpkt_cotp_header_scanner test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/tcs_pkg.sv
src/tcs_in_if.sv
src/tcs_out_if.sv
src/tcs_cfg.sv
src/tcs_parse.sv
src/tpkt_cotp_header_scanner.sv
tb/sv/tpkt_cotp_header_scanner_tb.sv
